// ===== src/hse_pkg.sv =====
package hse_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5C;
    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW = 2'd1;
    localparam logic [1:0] REG_HASH_MODE = 2'd2;

    // byte source select
    localparam logic [2:0] SRC_DATA = 3'd0;
    localparam logic [2:0] SRC_IPAD = 3'd1;
    localparam logic [2:0] SRC_OPAD = 3'd2;
    localparam logic [2:0] SRC_MARK = 3'd3;
    localparam logic [2:0] SRC_ZERO = 3'd4;
    localparam logic [2:0] SRC_LEN = 3'd5;
    localparam logic [2:0] SRC_INNER = 3'd6;

    typedef struct packed {
        logic       start_chain;
        logic       put_byte;
        logic [2:0] src;
        logic       count_bits;
        logic [5:0] sel;
        logic       round_start;
        logic       round_step;
        logic       round_finish;
        logic       save_inner;
        logic       snap_len;
    } hse_cmd_t;

    typedef struct packed {
        logic [5:0] byte_pos;
        logic       rounds_done;
    } hse_stat_t;

endpackage

// ===== src/hmac_sha1_engine_top.sv =====
// channel   signals                                 dir
// input     in_valid in_stall data_byte has_byte last   in
// output    out_valid out_stall digest_word word_index last_word  out
// config    cfg_we cfg_index cfg_data                in
// Each item passes the holding stage into the engine; no new item enters until it is taken.
// Each full block runs 80 rounds (S_ROUND), then one chain update (S_FIN).
// HMAC: the ipad block runs before the first byte; after the inner padding the outer
// pass hashes the opad block and the inner digest. Plain: padding bytes plus each block's rounds.
// The five digest words leave one per cycle; out_stall holds the current word.
// Reset (async, rst_n low) loads the SHA-1 initial values, hash_mode = 1.
module hmac_sha1_engine_top
    import hse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key_high_reg, key_low_reg;
    logic        mode_reg;
    logic        dp_stall;
    logic        pend_reg, pend_has_reg, pend_last_reg;
    logic [7:0]  pend_byte_reg;
    logic        c_valid, c_stall, c_has, c_last;
    logic [7:0]  c_byte;
    hse_cmd_t    cmd;
    hse_stat_t   stat;
    logic [2:0]  sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg <= '0;
            mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_HIGH:  key_high_reg <= cfg_data;
                REG_KEY_LOW:   key_low_reg <= cfg_data;
                REG_HASH_MODE: mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // one-item holding stage: the engine takes the item from here
    assign in_stall = pend_reg;
    assign c_valid = pend_reg;
    assign c_has = pend_has_reg;
    assign c_last = pend_last_reg;
    assign c_byte = pend_byte_reg;
    assign dp_stall = c_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (pend_reg && !dp_stall && !(cmd.start_chain && mode_reg && cmd.src == SRC_DATA
                 && !cmd.put_byte))
            pend_reg <= 1'b0;
        else if (!pend_reg && in_valid)
            pend_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!pend_reg && in_valid)
        begin
            pend_byte_reg <= data_byte;
            pend_has_reg <= has_byte;
            pend_last_reg <= last;
        end
    end

    hse_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(c_valid), .in_stall(c_stall),
        .has_byte(c_has), .last(c_last), .mode(mode_reg),
        .out_stall(out_stall), .out_valid(out_valid), .out_sel(sel),
        .stat(stat), .cmd(cmd)
    );

    hse_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .data_byte(c_byte), .key({key_high_reg, key_low_reg}),
        .out_sel(sel), .digest_word(digest_word)
    );

    assign word_index = sel;
    assign last_word = (sel == 3'd4);

endmodule

// ===== src/hse_datapath.sv =====
module hse_datapath
    import hse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  hse_cmd_t     cmd,
    output hse_stat_t    stat,
    input  logic [7:0]   data_byte,
    input  logic [127:0] key,
    input  logic [2:0]   out_sel,
    output logic [31:0]  digest_word
);

    logic [31:0] h_reg [5];
    logic [31:0] wr_reg [5];
    logic [31:0] w_reg [16];
    logic [31:0] inner_reg [5];
    logic [5:0]  pos_reg;
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic [6:0]  rnd_reg;

    logic [7:0]  key_b;
    logic [7:0]  byte_v;
    logic [31:0] inner_w;
    logic [31:0] wnew, wcur, f, k, t;
    logic [3:0]  ri;
    logic [3:0]  i3, i8, i14;

    always_comb
    begin
        key_b = (cmd.sel < 6'd16) ? key[127 - 8*cmd.sel[3:0] -: 8] : 8'h00;
        inner_w = inner_reg[(cmd.sel[4:2] > 3'd4) ? 3'd4 : cmd.sel[4:2]];
        case (cmd.src)
            SRC_DATA:  byte_v = data_byte;
            SRC_IPAD:  byte_v = key_b ^ IPAD;
            SRC_OPAD:  byte_v = key_b ^ OPAD;
            SRC_MARK:  byte_v = PAD_MARK;
            SRC_LEN:   byte_v = len_reg[63 - 8*cmd.sel[2:0] -: 8];
            SRC_INNER: byte_v = inner_w[31 - 8*cmd.sel[1:0] -: 8];
            default:   byte_v = 8'h00;
        endcase
    end

    always_comb
    begin
        ri = rnd_reg[3:0];
        i3 = ri - 4'd3;
        i8 = ri - 4'd8;
        i14 = ri - 4'd14;
        wnew = w_reg[i3] ^ w_reg[i8] ^ w_reg[i14] ^ w_reg[ri];
        wnew = {wnew[30:0], wnew[31]};
        wcur = (rnd_reg < 7'd16) ? w_reg[ri] : wnew;
        if (rnd_reg < 7'd20)
        begin
            f = (wr_reg[1] & wr_reg[2]) | (~wr_reg[1] & wr_reg[3]);
            k = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = wr_reg[1] ^ wr_reg[2] ^ wr_reg[3];
            k = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (wr_reg[1] & wr_reg[2]) | (wr_reg[1] & wr_reg[3]) | (wr_reg[2] & wr_reg[3]);
            k = K2;
        end
        else
        begin
            f = wr_reg[1] ^ wr_reg[2] ^ wr_reg[3];
            k = K3;
        end
        t = {wr_reg[0][26:0], wr_reg[0][31:27]} + f + wr_reg[4] + k + wcur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            bits_reg <= '0;
            rnd_reg <= '0;
            h_reg[0] <= IV0; h_reg[1] <= IV1; h_reg[2] <= IV2;
            h_reg[3] <= IV3; h_reg[4] <= IV4;
        end
        else
        begin
            if (cmd.start_chain)
            begin
                pos_reg <= '0;
                bits_reg <= '0;
                h_reg[0] <= IV0; h_reg[1] <= IV1; h_reg[2] <= IV2;
                h_reg[3] <= IV3; h_reg[4] <= IV4;
            end
            if (cmd.put_byte)
            begin
                pos_reg <= pos_reg + 6'd1;
                if (cmd.count_bits)
                    bits_reg <= bits_reg + 64'd8;
            end
            if (cmd.round_start)
                rnd_reg <= '0;
            else if (cmd.round_step)
                rnd_reg <= rnd_reg + 7'd1;
            if (cmd.round_finish)
                for (int j = 0; j < 5; j++)
                    h_reg[j] <= h_reg[j] + wr_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put_byte)
            w_reg[pos_reg[5:2]][31 - 8*pos_reg[1:0] -: 8] <= byte_v;
        if (cmd.snap_len)
            len_reg <= bits_reg;
        if (cmd.save_inner)
            for (int j = 0; j < 5; j++)
                inner_reg[j] <= h_reg[j];
        if (cmd.round_start)
            for (int j = 0; j < 5; j++)
                wr_reg[j] <= h_reg[j];
        else if (cmd.round_step)
        begin
            if (rnd_reg >= 7'd16)
                w_reg[ri] <= wnew;
            wr_reg[4] <= wr_reg[3];
            wr_reg[3] <= wr_reg[2];
            wr_reg[2] <= {wr_reg[1][1:0], wr_reg[1][31:2]};
            wr_reg[1] <= wr_reg[0];
            wr_reg[0] <= t;
        end
    end

    assign stat.byte_pos = pos_reg;
    assign stat.rounds_done = (rnd_reg == 7'd79);
    assign digest_word = h_reg[(out_sel > 3'd4) ? 3'd4 : out_sel];

endmodule

// ===== src/hse_ctrl.sv =====
module hse_ctrl
    import hse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      has_byte,
    input  logic      last,
    input  logic      mode,
    input  logic      out_stall,
    output logic      out_valid,
    output logic [2:0] out_sel,
    input  hse_stat_t stat,
    output hse_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_IPAD  = 4'd1;
    localparam logic [3:0] S_DATA  = 4'd2;
    localparam logic [3:0] S_MARK  = 4'd3;
    localparam logic [3:0] S_ZERO  = 4'd4;
    localparam logic [3:0] S_LEN   = 4'd5;
    localparam logic [3:0] S_OPAD  = 4'd6;
    localparam logic [3:0] S_INNER = 4'd7;
    localparam logic [3:0] S_ROUND = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] state_reg, state_next, ret_reg, ret_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       open_reg, open_next;
    logic       hmac_reg, hmac_next;
    logic       outer_reg, outer_next;
    logic       acc;

    // a byte put leading to a full block goes to the round loop, then ret
    function automatic logic [3:0] after_put(input logic [5:0] pos, input logic [3:0] ret);
        return (pos == 6'd63) ? S_ROUND : ret;
    endfunction

    assign in_stall = !(state_reg == S_DATA);
    assign acc = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);
    assign out_sel = cnt_reg[2:0];

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        cnt_next = cnt_reg;
        open_next = open_reg;
        hmac_next = hmac_reg;
        outer_next = outer_reg;
        cmd = '0;
        cmd.sel = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                cmd.src = SRC_DATA;
                if (acc && (has_byte || last))
                begin
                    if (!open_reg)
                    begin
                        // first item: open the message, maybe absorb ipad first
                        cmd.start_chain = mode;
                        open_next = 1'b1;
                        hmac_next = mode;
                        outer_next = 1'b0;
                        if (mode)
                        begin
                            state_next = S_IPAD;
                            cnt_next = '0;
                        end
                    end
                    if (open_reg || !mode)
                    begin
                        if (has_byte)
                        begin
                            cmd.put_byte = 1'b1;
                            cmd.count_bits = 1'b1;
                        end
                        if (last)
                        begin
                            ret_next = S_MARK;
                            state_next = has_byte ? after_put(stat.byte_pos, S_MARK) : S_MARK;
                        end
                        else if (has_byte)
                            begin
                                ret_next = S_DATA;
                                state_next = after_put(stat.byte_pos, S_DATA);
                            end
                    end
                end
            end
            S_IPAD:
            begin
                // the first item stays in the holding stage and is taken after the key block
                cmd.src = SRC_IPAD;
                cmd.put_byte = 1'b1;
                cmd.count_bits = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                ret_next = (cnt_reg == 6'd63) ? S_DATA : S_IPAD;
                state_next = after_put(stat.byte_pos, S_IPAD);
            end
            S_MARK:
            begin
                cmd.src = SRC_MARK;
                cmd.put_byte = 1'b1;
                cmd.snap_len = 1'b1;
                ret_next = (stat.byte_pos == 6'd55) ? S_LEN : S_ZERO;
                cnt_next = '0;
                state_next = after_put(stat.byte_pos, ret_next);
            end
            S_ZERO:
            begin
                cmd.src = SRC_ZERO;
                cmd.put_byte = 1'b1;
                ret_next = (stat.byte_pos == 6'd55) ? S_LEN : S_ZERO;
                cnt_next = '0;
                state_next = after_put(stat.byte_pos, ret_next);
            end
            S_LEN:
            begin
                cmd.src = SRC_LEN;
                cmd.put_byte = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                state_next = S_LEN;
                if (cnt_reg == 6'd7)
                begin
                    state_next = S_ROUND;
                    ret_next = (hmac_reg && !outer_reg) ? S_OPAD : S_OUT;
                    cnt_next = '0;
                end
            end
            S_OPAD:
            begin
                cmd.src = SRC_OPAD;
                if (cnt_reg == 6'd0 && !outer_reg)
                begin
                    cmd.save_inner = 1'b1;
                    cmd.start_chain = 1'b1;
                    outer_next = 1'b1;
                end
                else
                begin
                    cmd.put_byte = 1'b1;
                    cmd.count_bits = 1'b1;
                    cnt_next = cnt_reg + 6'd1;
                    ret_next = (cnt_reg == 6'd63) ? S_INNER : S_OPAD;
                    if (cnt_reg == 6'd63)
                        cnt_next = '0;
                    state_next = after_put(stat.byte_pos, ret_next);
                end
            end
            S_INNER:
            begin
                cmd.src = SRC_INNER;
                cmd.put_byte = 1'b1;
                cmd.count_bits = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                state_next = (cnt_reg == 6'd19) ? S_MARK : S_INNER;
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (stat.rounds_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.round_finish = 1'b1;
                state_next = ret_reg;
                if (ret_reg == S_OUT)
                    cnt_next = '0;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd4)
                    begin
                        cnt_next = '0;
                        open_next = 1'b0;
                        cmd.start_chain = 1'b1;
                        state_next = S_DATA;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_next == S_ROUND && state_reg != S_ROUND)
            cmd.round_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_DATA;
            cnt_reg <= '0;
            open_reg <= 1'b0;
            hmac_reg <= 1'b0;
            outer_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            cnt_reg <= cnt_next;
            open_reg <= open_next;
            hmac_reg <= hmac_next;
            outer_reg <= outer_next;
        end
    end

endmodule
